[src/cpu6502_address_mode_unit_core_assert.svh]
// assertion macros for the address mode unit
`ifndef CPU6502_ADDRESS_MODE_UNIT_CORE_ASSERT_SVH
`define CPU6502_ADDRESS_MODE_UNIT_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define AMU_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("address mode unit check failed");

// next-cycle implication, disabled while reset is asserted
`define AMU_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("address mode unit check failed");

`endif

[src/cpu6502amu_pkg.sv]
package cpu6502amu_pkg;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    localparam logic [3:0] MODE_IMM  = 4'd0;
    localparam logic [3:0] MODE_ZP   = 4'd1;
    localparam logic [3:0] MODE_ZPX  = 4'd2;
    localparam logic [3:0] MODE_ZPY  = 4'd3;
    localparam logic [3:0] MODE_ABS  = 4'd4;
    localparam logic [3:0] MODE_ABSX = 4'd5;
    localparam logic [3:0] MODE_ABSY = 4'd6;
    localparam logic [3:0] MODE_IND  = 4'd7;
    localparam logic [3:0] MODE_INDX = 4'd8;
    localparam logic [3:0] MODE_INDY = 4'd9;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    localparam logic [15:0] PAGE_MASK   = 16'hFF00;
    localparam logic [15:0] OFFSET_MASK = 16'h00FF;

    localparam logic [2:0] CYC_NONE    = 3'd0;
    localparam logic [2:0] CYC_ZP      = 3'd1;
    localparam logic [2:0] CYC_ZP_IDX  = 3'd2;
    localparam logic [2:0] CYC_ABS     = 3'd2;
    localparam logic [2:0] CYC_ABS_IDX = 3'd3;
    localparam logic [2:0] CYC_PTR     = 3'd4;
    localparam logic [2:0] CYC_MAX     = 3'd5;

    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_OPER_LO,
        STEP_OPER_HI,
        STEP_PTR_LO,
        STEP_PTR_HI
    } step_t;

    typedef struct packed {
        logic        command;
        logic [3:0]  mode;
        logic [15:0] pc;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  read_data;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] read_address;
        logic [15:0] effective_address;
        logic [15:0] next_pc;
        logic [2:0]  extra_cycles;
    } res_item_t;

endpackage

[src/cpu6502amu_in_stage.sv]
module cpu6502amu_in_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // mode[3:0], pc[19:4], index_x[27:20], index_y[35:28], read_data[43:36]
    input  logic [cpu6502amu_pkg::S_DATA_W-1:0] s_tdata,
    // command
    input  logic                                s_tuser,
    input  logic                                advance_i,
    output logic                                valid_o,
    output cpu6502amu_pkg::in_item_t            item_o
);
    import cpu6502amu_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;
    in_item_t item_next;
    logic     fire;

    assign s_tready = !valid_reg || advance_i;
    assign fire     = s_tvalid && s_tready;

    always_comb begin
        item_next.command   = s_tuser;
        item_next.mode      = s_tdata[3:0];
        item_next.pc        = s_tdata[19:4];
        item_next.index_x   = s_tdata[27:20];
        item_next.index_y   = s_tdata[35:28];
        item_next.read_data = s_tdata[43:36];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (fire) begin
            valid_reg <= 1'b1;
        end else if (advance_i) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            item_reg <= item_next;
        end
    end

    assign valid_o = valid_reg;
    assign item_o  = item_reg;

endmodule

[src/cpu6502amu_resolver.sv]
module cpu6502amu_resolver (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      item_valid_i,
    input  cpu6502amu_pkg::in_item_t  item_i,
    output logic                      res_valid_o,
    output cpu6502amu_pkg::res_item_t res_o,
    output cpu6502amu_pkg::step_t     step_o
);
    import cpu6502amu_pkg::*;

    step_t       step_reg, step_next;
    logic [3:0]  mode_reg, mode_next;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  x_reg, x_next;
    logic [7:0]  y_reg, y_next;
    logic [15:0] ptr_reg, ptr_next;
    logic [7:0]  low_reg, low_next;

    logic [7:0]  data;
    logic [7:0]  zp_x;
    logic [7:0]  zp_y;
    logic [15:0] base;
    logic [15:0] base_idx;
    logic [15:0] base_y;
    logic [15:0] ptr_inc;
    logic [15:0] ptr_hi_addr;
    logic [15:0] pc_inc1;
    logic [15:0] pc_inc2;

    function automatic res_item_t make_request(input logic [15:0] addr);
        res_item_t r;
        r                   = '0;
        r.result_kind       = KIND_REQUEST;
        r.read_address      = addr;
        return r;
    endfunction

    function automatic res_item_t make_done(input logic [15:0] ea, input logic [15:0] npc,
                                            input logic [2:0] cyc);
        res_item_t r;
        r                   = '0;
        r.result_kind       = KIND_DONE;
        r.effective_address = ea;
        r.next_pc           = npc;
        r.extra_cycles      = cyc;
        return r;
    endfunction

    function automatic logic [2:0] page_cross(input logic [15:0] a, input logic [15:0] b);
        return ((a & PAGE_MASK) != (b & PAGE_MASK)) ? 3'd1 : 3'd0;
    endfunction

    assign data     = item_i.read_data;
    assign zp_x     = data + x_reg;
    assign zp_y     = data + y_reg;
    assign base     = {data, low_reg};
    assign base_idx = base + {8'h00, (mode_reg == MODE_ABSX) ? x_reg : y_reg};
    assign base_y   = base + {8'h00, y_reg};
    assign ptr_inc  = ptr_reg + 16'd1;
    assign pc_inc1  = pc_reg + 16'd1;
    assign pc_inc2  = pc_reg + 16'd2;

    // indirect jump keeps the high fetch in the same page; zero-page pointers wrap in page zero
    always_comb begin
        if (mode_reg == MODE_IND) begin
            if ((ptr_reg & OFFSET_MASK) == OFFSET_MASK) begin
                ptr_hi_addr = ptr_reg & PAGE_MASK;
            end else begin
                ptr_hi_addr = ptr_inc;
            end
        end else begin
            ptr_hi_addr = ptr_inc & OFFSET_MASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        pc_reg   <= pc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        ptr_reg  <= ptr_next;
        low_reg  <= low_next;
    end

    always_comb begin
        step_next   = step_reg;
        mode_next   = mode_reg;
        pc_next     = pc_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        ptr_next    = ptr_reg;
        low_next    = low_reg;
        res_valid_o = 1'b0;
        res_o       = '0;

        if (item_valid_i) begin
            if (item_i.command == CMD_START) begin
                mode_next   = item_i.mode;
                pc_next     = item_i.pc;
                x_next      = item_i.index_x;
                y_next      = item_i.index_y;
                ptr_next    = '0;
                low_next    = '0;
                res_valid_o = 1'b1;
                if (item_i.mode == MODE_IMM) begin
                    step_next = STEP_IDLE;
                    res_o     = make_done(item_i.pc, item_i.pc + 16'd1, CYC_NONE);
                end else if (item_i.mode > MODE_INDY) begin
                    step_next = STEP_IDLE;
                    res_o     = make_done(16'h0000, item_i.pc, CYC_NONE);
                end else begin
                    step_next = STEP_OPER_LO;
                    res_o     = make_request(item_i.pc);
                end
            end else begin
                unique case (step_reg)
                    STEP_OPER_LO: begin
                        res_valid_o = 1'b1;
                        unique case (mode_reg)
                            MODE_ZP: begin
                                step_next = STEP_IDLE;
                                res_o     = make_done({8'h00, data}, pc_inc1, CYC_ZP);
                            end
                            MODE_ZPX: begin
                                step_next = STEP_IDLE;
                                res_o     = make_done({8'h00, zp_x}, pc_inc1, CYC_ZP_IDX);
                            end
                            MODE_ZPY: begin
                                step_next = STEP_IDLE;
                                res_o     = make_done({8'h00, zp_y}, pc_inc1, CYC_ZP_IDX);
                            end
                            MODE_INDX: begin
                                ptr_next  = {8'h00, zp_x};
                                step_next = STEP_PTR_LO;
                                res_o     = make_request({8'h00, zp_x});
                            end
                            MODE_INDY: begin
                                ptr_next  = {8'h00, data};
                                step_next = STEP_PTR_LO;
                                res_o     = make_request({8'h00, data});
                            end
                            default: begin
                                low_next  = data;
                                step_next = STEP_OPER_HI;
                                res_o     = make_request(pc_inc1);
                            end
                        endcase
                    end
                    STEP_OPER_HI: begin
                        res_valid_o = 1'b1;
                        if (mode_reg == MODE_ABSX || mode_reg == MODE_ABSY) begin
                            step_next = STEP_IDLE;
                            res_o     = make_done(base_idx, pc_inc2,
                                                  CYC_ABS_IDX + page_cross(base, base_idx));
                        end else if (mode_reg == MODE_IND) begin
                            ptr_next  = base;
                            step_next = STEP_PTR_LO;
                            res_o     = make_request(base);
                        end else begin
                            step_next = STEP_IDLE;
                            res_o     = make_done(base, pc_inc2, CYC_ABS);
                        end
                    end
                    STEP_PTR_LO: begin
                        res_valid_o = 1'b1;
                        low_next    = data;
                        step_next   = STEP_PTR_HI;
                        res_o       = make_request(ptr_hi_addr);
                    end
                    STEP_PTR_HI: begin
                        res_valid_o = 1'b1;
                        step_next   = STEP_IDLE;
                        if (mode_reg == MODE_IND) begin
                            res_o = make_done(base, pc_reg, CYC_NONE);
                        end else if (mode_reg == MODE_INDY) begin
                            res_o = make_done(base_y, pc_inc1,
                                              CYC_PTR + page_cross(base, base_y));
                        end else begin
                            res_o = make_done(base, pc_inc1, CYC_PTR);
                        end
                    end
                    default: begin
                        // byte with nothing pending is dropped
                        step_next = STEP_IDLE;
                    end
                endcase
            end
        end
    end

    assign step_o = step_reg;

endmodule

[src/cpu6502amu_out_stage.sv]
module cpu6502amu_out_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load_i,
    input  cpu6502amu_pkg::res_item_t           res_i,
    output logic                                ready_o,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // read_address[15:0], effective_address[31:16], next_pc[47:32],
    // extra_cycles[50:48], zero fill [55:51]
    output logic [cpu6502amu_pkg::M_DATA_W-1:0] m_tdata,
    // result_kind
    output logic                                m_tuser
);
    import cpu6502amu_pkg::*;

    logic      valid_reg;
    res_item_t res_reg;

    assign ready_o = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_i) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            res_reg <= res_i;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.result_kind;
    assign m_tdata  = {5'b00000, res_reg.extra_cycles, res_reg.next_pc,
                       res_reg.effective_address, res_reg.read_address};

endmodule

[src/cpu6502_address_mode_unit_core.sv]
// channel  | direction | tdata                                         | tuser
// s_       | in        | mode, pc, index_x, index_y, read_data (48b)   | command
// m_       | out       | read_address, effective_address, next_pc,     | result_kind
//          |           | extra_cycles (56b)                            |
//
// one transaction per cycle in each direction while m_tready is held high; a result passes
// through the input register and then the result register
// the address sequencer updates its state as an item leaves the input register, so the
// next item sees it in the following cycle
// aresetn (synchronous) clears both valid flags and returns the sequencer to idle
// a stall on m_ holds the input register and drops s_tready once both stages are full
`include "cpu6502_address_mode_unit_core_assert.svh"

module cpu6502_address_mode_unit_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // mode[3:0], pc[19:4], index_x[27:20], index_y[35:28], read_data[43:36]
    input  logic [cpu6502amu_pkg::S_DATA_W-1:0] s_tdata,
    // command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // read_address[15:0], effective_address[31:16], next_pc[47:32], extra_cycles[50:48]
    output logic [cpu6502amu_pkg::M_DATA_W-1:0] m_tdata,
    // result_kind
    output logic                                m_tuser
);
    import cpu6502amu_pkg::*;

    logic      in_valid;
    in_item_t  in_item;
    logic      out_ready;
    logic      advance;
    logic      res_valid;
    res_item_t res;
    step_t     step;

    assign advance = in_valid && out_ready;

    cpu6502amu_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .advance_i (advance),
        .valid_o   (in_valid),
        .item_o    (in_item)
    );

    cpu6502amu_resolver u_resolver (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid_i (advance),
        .item_i       (in_item),
        .res_valid_o  (res_valid),
        .res_o        (res),
        .step_o       (step)
    );

    cpu6502amu_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (advance && res_valid),
        .res_i    (res),
        .ready_o  (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `AMU_ASSERT_IMPLY(a_request_fields_clear, aclk, aresetn, m_tvalid && m_tuser == KIND_REQUEST, m_tdata[50:16] == 35'd0)
    `AMU_ASSERT_IMPLY(a_done_fields_sane, aclk, aresetn, m_tvalid && m_tuser == KIND_DONE, m_tdata[15:0] == 16'h0000 && m_tdata[50:48] <= CYC_MAX)
    `AMU_ASSERT_NEXT(a_done_returns_idle, aclk, aresetn, res_valid && res.result_kind == KIND_DONE, step == STEP_IDLE)
    `AMU_ASSERT_NEXT(a_request_stays_busy, aclk, aresetn, res_valid && res.result_kind == KIND_REQUEST, step != STEP_IDLE)

endmodule
